[sv/cppt_pkg.sv]
// ---------------------------------------------------------------------------
// cppt_pkg: shared types and constants for the code page pair table lookup
// Widths, codes, state encoding and controller/datapath structs.
// ---------------------------------------------------------------------------
package cppt_pkg;

    localparam int TABLE_DEPTH = 32768;
    localparam int PROBE_COUNT = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PROBE_W     = $clog2(PROBE_COUNT + 1);
    localparam int CODE_W      = 16;
    localparam int IDX_W       = 15;
    localparam int CNT_W       = 16;
    localparam int ENTRY_W     = 2 * CODE_W;
    localparam int STATUS_W    = 2;

    localparam logic [CODE_W-1:0] ASCII_LIMIT = CODE_W'(16'h0080);

    // operation field
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // direction field
    localparam logic DIR_UNI_TO_OEM = 1'b0;
    localparam logic DIR_OEM_TO_UNI = 1'b1;

    // configuration register indexes
    localparam logic CFG_OEM_TO_UNI_COUNT = 1'b0;
    localparam logic CFG_UNI_TO_OEM_COUNT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ASCII = 2'd0,
        ST_FOUND = 2'd1,
        ST_MISS  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;    // request taken this cycle
        logic start;     // latch a convert request, set up search
        logic step;      // consume one probe result
        logic load_out;  // move result to output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_convert;  // pending request is a convert
        logic short_path;  // ASCII or empty table: no search needed
        logic hit;         // current probe matched
        logic last_probe;  // current probe is the final one
        logic out_free;    // output register can take a result
    } t_dp_status;

endpackage

[sv/cppt_if.sv]
// ---------------------------------------------------------------------------
// cppt_if: request and response channels
// Valid/ready channels carrying the request item and the response item.
// ---------------------------------------------------------------------------
interface cppt_req_if;
    import cppt_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic              direction;
    logic [CODE_W-1:0] code_in;
    logic [IDX_W-1:0]  entry_index;
    logic [CODE_W-1:0] entry_key;
    logic [CODE_W-1:0] entry_value;

    modport source (
        output valid, operation, direction, code_in, entry_index, entry_key, entry_value,
        input  ready
    );
    modport sink (
        input  valid, operation, direction, code_in, entry_index, entry_key, entry_value,
        output ready
    );
endinterface

interface cppt_rsp_if;
    import cppt_pkg::*;

    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   code_out;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, code_out, status,
        input  ready
    );
    modport sink (
        input  valid, code_out, status,
        output ready
    );
endinterface

[sv/cppt_ram.sv]
// ---------------------------------------------------------------------------
// cppt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/cppt_ctrl.sv]
// ---------------------------------------------------------------------------
// cppt_ctrl: request sequencer
// Accepts requests, runs the probe sequence and hands off the result.
// ---------------------------------------------------------------------------
module cppt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  cppt_pkg::t_dp_status  i_status,
    output cppt_pkg::t_dp_cmd     o_cmd
);
    import cppt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.is_convert) begin
                        o_cmd.start = 1'b1;
                        n_state     = i_status.short_path ? S_DONE : S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                o_cmd.step = 1'b1;
                if (i_status.hit || i_status.last_probe) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

[sv/cppt_dp.sv]
// ---------------------------------------------------------------------------
// cppt_dp: lookup datapath
// Count registers, both pair tables, search bounds and the output register.
// ---------------------------------------------------------------------------
module cppt_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [cppt_pkg::CNT_W-1:0]      i_cfg_data,
    input  logic                            i_operation,
    input  logic                            i_direction,
    input  logic [cppt_pkg::CODE_W-1:0]     i_code_in,
    input  logic [cppt_pkg::IDX_W-1:0]      i_entry_index,
    input  logic [cppt_pkg::CODE_W-1:0]     i_entry_key,
    input  logic [cppt_pkg::CODE_W-1:0]     i_entry_value,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [cppt_pkg::CODE_W-1:0]     o_code_out,
    output logic [cppt_pkg::STATUS_W-1:0]   o_status,
    input  cppt_pkg::t_dp_cmd               i_cmd,
    output cppt_pkg::t_dp_status            o_status_ctl
);
    import cppt_pkg::*;

    logic [CNT_W-1:0]  r_cnt_o2u;
    logic [CNT_W-1:0]  r_cnt_u2o;
    logic [CODE_W-1:0] r_code,     n_code;
    logic              r_dir,      n_dir;
    logic [ADDR_W-1:0] r_lo,       n_lo;
    logic [ADDR_W-1:0] r_hi,       n_hi;
    logic [ADDR_W-1:0] r_mid,      n_mid;
    logic [PROBE_W-1:0] r_probe,   n_probe;
    logic [CODE_W-1:0] r_res_code, n_res_code;
    t_status           r_res_st,   n_res_st;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    t_status           r_out_st;

    logic [CNT_W-1:0]   sel_cnt;
    logic [ADDR_W-1:0]  hi_init;
    logic               is_ascii;
    logic               in_range;
    logic [ENTRY_W-1:0] o2u_rdata;
    logic [ENTRY_W-1:0] u2o_rdata;
    logic [ENTRY_W-1:0] rdata;
    logic [CODE_W-1:0]  key;
    logic               hit;
    logic               we_load;
    logic [ENTRY_W-1:0] wdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_o2u <= '0;
            r_cnt_u2o <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_OEM_TO_UNI_COUNT) begin
                r_cnt_o2u <= i_cfg_data;
            end else begin
                r_cnt_u2o <= i_cfg_data;
            end
        end
    end

    // table loads
    assign in_range = 32'(i_entry_index) < 32'(TABLE_DEPTH);
    assign we_load  = i_cmd.accept && (i_operation == OP_LOAD) && in_range;
    assign wdata    = {i_entry_key, i_entry_value};

    cppt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_o2u_ram (
        .i_clk   (i_clk),
        .i_we    (we_load && (i_direction == DIR_OEM_TO_UNI)),
        .i_waddr (ADDR_W'(i_entry_index)),
        .i_wdata (wdata),
        .i_raddr (n_mid),
        .o_rdata (o2u_rdata)
    );

    cppt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_u2o_ram (
        .i_clk   (i_clk),
        .i_we    (we_load && (i_direction == DIR_UNI_TO_OEM)),
        .i_waddr (ADDR_W'(i_entry_index)),
        .i_wdata (wdata),
        .i_raddr (n_mid),
        .o_rdata (u2o_rdata)
    );

    always_comb begin
        sel_cnt  = (i_direction == DIR_OEM_TO_UNI) ? r_cnt_o2u : r_cnt_u2o;
        is_ascii = i_code_in < ASCII_LIMIT;
        // counts past the table depth clamp to the depth
        hi_init  = (32'(sel_cnt) >= 32'(TABLE_DEPTH)) ? ADDR_W'(TABLE_DEPTH - 1)
                                                      : ADDR_W'(sel_cnt - CNT_W'(1));
        rdata    = (r_dir == DIR_OEM_TO_UNI) ? o2u_rdata : u2o_rdata;
        key      = rdata[ENTRY_W-1:CODE_W];
        hit      = r_code == key;

        n_code     = r_code;
        n_dir      = r_dir;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_probe    = r_probe;
        n_res_code = r_res_code;
        n_res_st   = r_res_st;

        if (i_cmd.start) begin
            n_code  = i_code_in;
            n_dir   = i_direction;
            n_lo    = '0;
            n_hi    = hi_init;
            n_probe = '0;
            if (is_ascii) begin
                n_res_code = i_code_in;
                n_res_st   = ST_ASCII;
            end else begin
                n_res_code = '0;
                n_res_st   = ST_MISS;
            end
        end else if (i_cmd.step) begin
            n_probe = r_probe + PROBE_W'(1);
            if (hit) begin
                n_res_code = rdata[CODE_W-1:0];
                n_res_st   = ST_FOUND;
            end else if (r_code > key) begin
                n_lo = r_mid;
            end else begin
                n_hi = r_mid;
            end
        end

        // midpoint of the next bounds addresses the next read
        n_mid = ADDR_W'(({1'b0, n_lo} + {1'b0, n_hi}) >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_dir      <= n_dir;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_probe    <= n_probe;
        r_res_code <= n_res_code;
        r_res_st   <= n_res_st;
        if (i_cmd.load_out) begin
            r_out_code <= r_res_code;
            r_out_st   <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code_out  = r_out_code;
    assign o_status    = r_out_st;

    assign o_status_ctl.is_convert = i_operation == OP_CONVERT;
    assign o_status_ctl.short_path = is_ascii || (sel_cnt == '0);
    assign o_status_ctl.hit        = hit;
    assign o_status_ctl.last_probe = r_probe == PROBE_W'(PROBE_COUNT - 1);
    assign o_status_ctl.out_free   = !r_out_valid || i_out_ready;
endmodule

[sv/code_page_pair_table_lookup_top.sv]
// ---------------------------------------------------------------------------
// code_page_pair_table_lookup_top: Unicode / code page converter
// Two sorted pair tables searched by a binary search of at most PROBE_COUNT probes.
// ---------------------------------------------------------------------------
// A load request writes one key/value pair into the table picked by
// direction in the cycle it is taken and gives no response. A convert
// request gives one response: codes below 0x80 come back unchanged with
// status ASCII, an empty table gives 0 with status miss, otherwise a
// binary search of up to PROBE_COUNT probes runs over the table's first
// count entries (count clamped to the table depth). Bounds move to the
// midpoint with no plus/minus one, so the search can miss keys that are
// present. One request is handled at a time; a search makes one probe
// per cycle, set by the registered read of the table memory feeding the
// next midpoint. A request is taken while a previous response still waits
// on the output register; a finished result then waits until that
// register frees. The user must write counts through the config port only
// while the block is idle; the block itself does not enforce it. Tables
// have no reset; searching entries never loaded gives undefined data.
// ---------------------------------------------------------------------------
module code_page_pair_table_lookup_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [cppt_pkg::CNT_W-1:0]  i_cfg_data,
    cppt_req_if.sink                    i_req,
    cppt_rsp_if.source                  o_rsp
);
    import cppt_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       req_ready;

    // sequencer: request handshake and probe loop
    cppt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    assign i_req.ready = req_ready;

    // tables, bounds and response register
    cppt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_req.operation),
        .i_direction   (i_req.direction),
        .i_code_in     (i_req.code_in),
        .i_entry_index (i_req.entry_index),
        .i_entry_key   (i_req.entry_key),
        .i_entry_value (i_req.entry_value),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_code_out    (o_rsp.code_out),
        .o_status      (o_rsp.status),
        .i_cmd         (cmd),
        .o_status_ctl  (status)
    );
endmodule
